@@ rtl/core/mrw_pkg.sv @@
// Shared types for the Miller-Rabin witness test core.
// Holds the request/response structs of the bit-serial modular multiplier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrw_pkg;

  // Operation of the modular unit: product x*y mod m, or reduction y mod m.
  typedef enum logic {
    MM_MUL    = 1'b0,
    MM_REDUCE = 1'b1
  } mm_op_e;

  typedef struct packed {
    logic   start;
    mm_op_e op;
  } mm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/mrw_modmul.sv @@
// Bit-serial modular multiplier and reducer for the witness test core.
// Walks y from its top bit, one doubling and at most one addition per bit.
// Depends on mrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrw_modmul import mrw_pkg::*; #(
  parameter int unsigned NUM_BITS = 63
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mm_req_t             req_i,
  input  wire logic [NUM_BITS-1:0] x_i,
  input  wire logic [NUM_BITS-1:0] y_i,
  input  wire logic [NUM_BITS-1:0] m_i,
  output mm_rsp_t                  rsp_o,
  output logic      [NUM_BITS-1:0] res_o
);

  localparam int unsigned CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] acc_q, acc_d, x_q, x_d, y_q, y_d, m_q, m_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                phase_q, phase_d, busy_q, busy_d, done_q, done_d;
  mm_op_e              op_q, op_d;

  logic                y_msb, add_cin, shift_en;
  logic [NUM_BITS-1:0] add_b, add_res;
  logic [NUM_BITS:0]   sum;
  logic [NUM_BITS+1:0] diff;

  // One modular add per cycle while busy: phase 0 doubles acc (adding the top bit of y when reducing), phase 1 adds x.
  always_comb begin
    y_msb    = y_q[NUM_BITS-1];
    add_b    = phase_q ? x_q : acc_q;
    add_cin  = !phase_q && (op_q == MM_REDUCE) && y_msb;
    sum      = {1'b0, acc_q} + {1'b0, add_b} + {{NUM_BITS{1'b0}}, add_cin};
    diff     = {1'b0, sum} - {2'b00, m_q};
    add_res  = diff[NUM_BITS+1] ? sum[NUM_BITS-1:0] : diff[NUM_BITS-1:0];
    shift_en = phase_q || !((op_q == MM_MUL) && y_msb);
  end

  always_comb begin
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    m_d     = m_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start && !busy_q) begin
      acc_d   = '0;
      x_d     = x_i;
      y_d     = y_i;
      m_d     = m_i;
      op_d    = req_i.op;
      cnt_d   = CW'(NUM_BITS);
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      acc_d   = add_res;
      phase_d = !shift_en;
      if (shift_en) begin
        y_d   = y_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
    op_q  <= op_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = acc_q;

  a_acc_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (acc_q < m_q))
    else $error("modmul accumulator not reduced");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("modmul started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("modmul done while still busy");

endmodule

`default_nettype wire

@@ rtl/core/miller_rabin_witness_test_top.sv @@
// Miller-Rabin strong probable-prime test of one candidate against one witness.
// done_o rises in the cycle after the start transfer for n < 4 or even n. Otherwise
// the sequencer strips the trailing zeros of n-1, reduces the witness mod n and
// runs at most 2*NUM_BITS-3 bit-serial modular products. One item at a time: busy stays
// high until done_o, the receiver cannot stall, and reset drops any item in flight.
`timescale 1ns / 1ps
`default_nettype none

module miller_rabin_witness_test_top import mrw_pkg::*; #(
  parameter int unsigned NUM_BITS = 63
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [NUM_BITS-1:0] candidate_i,
  input  wire logic [NUM_BITS-1:0] witness_base_i,
  output logic                     done_o,
  output logic                     probably_prime_o
);

  localparam int unsigned SW = $clog2(NUM_BITS);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SCAN  = 10'b0000000010,
    ST_RED   = 10'b0000000100,
    ST_PSTEP = 10'b0000001000,
    ST_PMUL  = 10'b0000010000,
    ST_PSQR  = 10'b0000100000,
    ST_CHK0  = 10'b0001000000,
    ST_LOOP  = 10'b0010000000,
    ST_SQ    = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e              state_q, state_d;
  logic [NUM_BITS-1:0] n_q, n_d, base_q, base_d, t_q, t_d, g_q, g_d;
  logic [SW-1:0]       s_q, s_d, k_q, k_d;
  logic                res_q, res_d;

  logic [NUM_BITS-1:0] nm1;
  mm_req_t             mm_req;
  mm_rsp_t             mm_rsp;
  logic [NUM_BITS-1:0] mm_x, mm_y, mm_res;
  logic                accept;

  // n is odd in every state that uses n-1, so n-1 just clears bit 0.
  assign nm1    = {n_q[NUM_BITS-1:1], 1'b0};
  assign accept = start && !busy;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    base_d     = base_q;
    t_d        = t_q;
    g_d        = g_q;
    s_d        = s_q;
    k_d        = k_q;
    res_d      = res_q;
    mm_req     = '{start: 1'b0, op: MM_MUL};
    mm_x       = g_q;
    mm_y       = base_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          n_d    = candidate_i;
          base_d = witness_base_i;
          t_d    = {candidate_i[NUM_BITS-1:1], 1'b0};
          s_d    = '0;
          // Settle the small and even cases right away.
          if (candidate_i[NUM_BITS-1:1] == '0) begin
            res_d   = 1'b0;
            state_d = ST_OUT;
          end else if (candidate_i[NUM_BITS-1:2] == '0) begin
            res_d   = 1'b1;
            state_d = ST_OUT;
          end else if (!candidate_i[0]) begin
            res_d   = 1'b0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Strip trailing zeros of n-1: t is the odd part, s the count.
        if (!t_q[0]) begin
          t_d = t_q >> 1;
          s_d = s_q + SW'(1);
        end else begin
          mm_req  = '{start: 1'b1, op: MM_REDUCE};
          mm_y    = base_q;
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        if (mm_rsp.done) begin
          base_d  = mm_res;
          g_d     = NUM_BITS'(1);
          state_d = ST_PSTEP;
        end
      end
      ST_PSTEP: begin
        mm_req = '{start: 1'b1, op: MM_MUL};
        if (t_q[0]) begin
          mm_x    = g_q;
          mm_y    = base_q;
          state_d = ST_PMUL;
        end else begin
          mm_x    = base_q;
          mm_y    = base_q;
          state_d = ST_PSQR;
        end
      end
      ST_PMUL: begin
        if (mm_rsp.done) begin
          g_d = mm_res;
          if (t_q == NUM_BITS'(1)) begin
            state_d = ST_CHK0;
          end else begin
            mm_req  = '{start: 1'b1, op: MM_MUL};
            mm_x    = base_q;
            mm_y    = base_q;
            state_d = ST_PSQR;
          end
        end
      end
      ST_PSQR: begin
        if (mm_rsp.done) begin
          base_d  = mm_res;
          t_d     = t_q >> 1;
          state_d = ST_PSTEP;
        end
      end
      ST_CHK0: begin
        if (g_q == NUM_BITS'(1) || g_q == nm1) begin
          res_d   = 1'b1;
          state_d = ST_OUT;
        end else begin
          k_d     = SW'(1);
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        // Up to s-1 squarings of g.
        if (k_q < s_q) begin
          mm_req  = '{start: 1'b1, op: MM_MUL};
          mm_x    = g_q;
          mm_y    = g_q;
          state_d = ST_SQ;
        end else begin
          res_d   = (g_q == NUM_BITS'(1));
          state_d = ST_OUT;
        end
      end
      ST_SQ: begin
        if (mm_rsp.done) begin
          g_d = mm_res;
          k_d = k_q + SW'(1);
          if (mm_res == NUM_BITS'(1)) begin
            res_d   = 1'b0;
            state_d = ST_OUT;
          end else if (mm_res == nm1) begin
            res_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            state_d = ST_LOOP;
          end
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    base_q <= base_d;
    t_q    <= t_d;
    g_q    <= g_d;
    s_q    <= s_d;
    k_q    <= k_d;
    res_q  <= res_d;
  end

  mrw_modmul #(
    .NUM_BITS(NUM_BITS)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .x_i    (mm_x),
    .y_i    (mm_y),
    .m_i    (n_q),
    .rsp_o  (mm_rsp),
    .res_o  (mm_res)
  );

  // Hold busy through the whole test; present the result for one cycle.
  assign busy             = (state_q != ST_IDLE);
  assign done_o           = (state_q == ST_OUT);
  assign probably_prime_o = res_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("start transfer did not raise busy");

  a_wait_has_mm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED || state_q == ST_PMUL || state_q == ST_PSQR ||
     state_q == ST_SQ) |-> (mm_rsp.busy || mm_rsp.done))
    else $error("sequencer waits on an idle multiplier");

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("sequencer not idle after result");

endmodule

`default_nettype wire
